// ----- hw/rtl/lpdk_pkg.sv -----
package lpdk_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_PONG     = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_TIMEOUT  = 2'd3
    } t_kind;

    // Input item kinds
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    // Configuration register indexes
    typedef enum logic {
        CFG_MAX_PACKET_SIZE = 1'b0,
        CFG_PING_INTERVAL   = 1'b1
    } t_cfg_index;

    localparam int unsigned HDR_BYTES  = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned POS_W      = 17;
    localparam int unsigned TICK_W     = 17;
    localparam int unsigned INTERVAL_W = 15;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_MAX         = '1;
    localparam logic [LEN_W-1:0]  MAX_PACKET_RESET = 16'd256;
    localparam logic [INTERVAL_W-1:0] PING_INTERVAL_RESET = 15'd1000;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last;
        logic [LEN_W-1:0]   frame_length;
    } t_result;

endpackage

// ----- hw/rtl/length_prefixed_deframer_keepalive.sv -----
// An accepted transaction's result is registered in r_out, or in r_skid on a stall.
// Throughput: one input transaction per cycle while o_stall is low; result and skid
// registers decouple the sides, and o_stall rises only when the skid holds a result.
// Reset (i_rst_n low, synchronous): clears framer state, keepalive count, error
// latch and output valids; max_packet_size returns to 256 and ping_interval to 1000.
module length_prefixed_deframer_keepalive (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  lpdk_pkg::t_op                        i_op,
    input  logic [lpdk_pkg::BYTE_W-1:0]          i_rx_byte,
    // Result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output lpdk_pkg::t_kind                      o_kind,
    output logic [lpdk_pkg::BYTE_W-1:0]          o_payload_byte,
    output logic                                 o_last,
    output logic [lpdk_pkg::LEN_W-1:0]           o_frame_length,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  lpdk_pkg::t_cfg_index                 i_cfg_index,
    input  logic [lpdk_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import lpdk_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0]      r_max_packet_size;
    logic [INTERVAL_W-1:0] r_ping_interval;

    // Framer and keepalive state
    logic [POS_W-1:0]  r_byte_position, n_byte_position;
    logic [LEN_W-1:0]  r_length_field,  n_length_field;
    logic [TICK_W-1:0] r_ticks,         n_ticks;
    logic              r_error,         n_error;

    // Result register and skid register
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    // Per-item combinational results
    logic              in_fire;
    logic              res_valid;
    t_result           res;
    logic [TICK_W-1:0] ticks_inc;
    logic [TICK_W-1:0] timeout_limit;
    logic [LEN_W-1:0]  hdr_length;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  frame_end;
    logic              out_free;

    // All config writes are taken; software must write only while idle, unenforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packet_size <= MAX_PACKET_RESET;
            r_ping_interval   <= PING_INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_PACKET_SIZE: r_max_packet_size <= i_cfg_data;
                CFG_PING_INTERVAL:   r_ping_interval   <= i_cfg_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept only while the skid register is empty, so any result has a home.
    assign o_stall = r_skid_valid;
    assign in_fire = i_valid && !r_skid_valid;

    // Doubled interval fits in 17 bits, so it never wraps.
    assign timeout_limit = {1'b0, r_ping_interval, 1'b0};
    assign ticks_inc     = (r_ticks < TICK_MAX) ? r_ticks + TICK_W'(1) : r_ticks;
    assign hdr_length    = {r_length_field[LEN_W-1:BYTE_W], i_rx_byte};
    assign pos_inc       = r_byte_position + POS_W'(1);
    assign frame_end     = {1'b0, r_length_field} + POS_W'(HDR_BYTES);

    always_comb begin
        n_byte_position = r_byte_position;
        n_length_field  = r_length_field;
        n_ticks         = r_ticks;
        n_error         = r_error;
        res_valid       = 1'b0;
        res             = '{kind: KIND_PAYLOAD, payload_byte: '0, last: 1'b0,
                            frame_length: '0};

        if (in_fire && !r_error) begin
            case (i_op)
                OP_TICK: begin
                    if (ticks_inc > timeout_limit) begin
                        // Timeout: drop any partial frame and restart the count
                        n_byte_position = '0;
                        n_length_field  = '0;
                        n_ticks         = '0;
                        res_valid       = 1'b1;
                        res.kind        = KIND_TIMEOUT;
                    end else begin
                        n_ticks = ticks_inc;
                    end
                end
                OP_BYTE: begin
                    if (r_byte_position == POS_W'(0)) begin
                        // High length byte
                        n_length_field  = {i_rx_byte, {BYTE_W{1'b0}}};
                        n_byte_position = POS_W'(1);
                    end else if (r_byte_position == POS_W'(1)) begin
                        // Low length byte: ping, oversize or start of payload
                        n_length_field = hdr_length;
                        if (hdr_length == '0) begin
                            n_ticks         = '0;
                            n_byte_position = '0;
                            res_valid       = 1'b1;
                            res.kind        = KIND_PONG;
                        end else if (hdr_length > r_max_packet_size) begin
                            n_byte_position  = '0;
                            n_error          = 1'b1;
                            res_valid        = 1'b1;
                            res.kind         = KIND_OVERSIZE;
                            res.frame_length = hdr_length;
                        end else begin
                            n_byte_position = POS_W'(HDR_BYTES);
                        end
                    end else begin
                        // Payload byte; mark and close the frame on the last one
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = i_rx_byte;
                        res.frame_length = r_length_field;
                        if (pos_inc >= frame_end) begin
                            n_byte_position = '0;
                            res.last        = 1'b1;
                        end else begin
                            n_byte_position = pos_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_length_field  <= '0;
            r_ticks         <= '0;
            r_error         <= 1'b0;
        end else begin
            r_byte_position <= n_byte_position;
            r_length_field  <= n_length_field;
            r_ticks         <= n_ticks;
            r_error         <= n_error;
        end
    end

    // Output stage: result register backed by a one-entry skid register.
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // No new transaction is taken while the skid holds a result
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (out_free) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_last         = r_out.last;
    assign o_frame_length = r_out.frame_length;

endmodule

// ----- hw/rtl/lpdk_checker.sv -----
module lpdk_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  lpdk_pkg::t_kind                      o_kind,
    input  logic [lpdk_pkg::BYTE_W-1:0]          o_payload_byte,
    input  logic                                 o_last,
    input  logic [lpdk_pkg::LEN_W-1:0]           o_frame_length
);
    import lpdk_pkg::*;

    // Only payload results carry a byte or a last mark
    a_non_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_PAYLOAD |-> o_payload_byte == '0 && !o_last)
        else $error("non-payload result carries byte or last");

    // Pong and timeout report no length
    a_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_PONG || o_kind == KIND_TIMEOUT)
            |-> o_frame_length == '0)
        else $error("pong or timeout with nonzero length");

    // Payload and oversize come only from a nonzero length field
    a_nonzero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_PAYLOAD || o_kind == KIND_OVERSIZE)
            |-> o_frame_length != '0)
        else $error("payload or oversize with zero length");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_payload_byte)
            && $stable(o_last) && $stable(o_frame_length))
        else $error("stalled result changed");

endmodule

bind length_prefixed_deframer_keepalive lpdk_checker u_lpdk_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte),
    .o_last         (o_last),
    .o_frame_length (o_frame_length)
);
